// ===== src/lsfd_pkg.sv =====
// Shared constants, types and arithmetic step functions of the LiDAR slope feature detector.
package lsfd_pkg;

  localparam int MAX_COLUMNS = 2048;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int CNT_W       = COL_W + 1;
  localparam int COORD_W     = 20;
  localparam int SLOPE_W     = 16;
  localparam int ROW_W       = 8;
  localparam int LABEL_W     = 8;

  // Squared segment length, its root, and the staging of the root and the division.
  localparam int SUM_W       = 42;
  localparam int ROOT_W      = 21;
  localparam int SQ_STEPS    = 21;
  localparam int SQ_PER      = 4;
  localparam int SQ_STAGES   = (SQ_STEPS + SQ_PER - 1) / SQ_PER;
  localparam int DV_PER      = 4;
  localparam int DV_STAGES   = SLOPE_W / DV_PER;

  localparam logic [CNT_W-1:0] MAX_COLS = CNT_W'(MAX_COLUMNS);

  // Configuration register indexes.
  localparam logic [2:0] REG_SLOPE_LIMIT     = 3'd0;
  localparam logic [2:0] REG_MIN_RANGE       = 3'd1;
  localparam logic [2:0] REG_SCORE_THRESHOLD = 3'd2;
  localparam logic [2:0] REG_MAP_EMPTY       = 3'd3;
  localparam logic [2:0] REG_COLUMN_COUNT    = 3'd4;

  typedef struct packed {
    logic               vld;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               row_ok;
    logic               far;
    logic [COORD_W-1:0] adz;
  } ctx_t;

  typedef struct packed {
    logic [SUM_W-1:0]  n;
    logic [ROOT_W+1:0] rem;
    logic [ROOT_W-1:0] root;
  } sqs_t;

  typedef struct packed {
    logic [ROOT_W-1:0]  rem;
    logic [ROOT_W-1:0]  seg_len;
    logic [SLOPE_W-1:0] q;
    logic               zero;
    logic               sat;
  } dvs_t;

  function automatic logic [COORD_W-1:0] abs_coord(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] n;
    n = ~v + COORD_W'(1);
    return v[COORD_W-1] ? n : v;
  endfunction

  function automatic logic [COORD_W:0] abs_diff(input logic [COORD_W:0] v);
    logic [COORD_W:0] n;
    n = ~v + (COORD_W+1)'(1);
    return v[COORD_W] ? n : v;
  endfunction

  // One digit of the bitwise integer square root.
  function automatic sqs_t sqrt_step(input sqs_t a);
    sqs_t r;
    logic [ROOT_W+3:0] t;
    logic [ROOT_W+3:0] trial;
    logic [ROOT_W+3:0] d;
    t     = {a.rem, a.n[SUM_W-1 -: 2]};
    trial = {2'b00, a.root, 2'b01};
    d     = t - trial;
    r.n   = {a.n[SUM_W-3:0], 2'b00};
    if (t >= trial) begin
      r.rem  = d[ROOT_W+1:0];
      r.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = t[ROOT_W+1:0];
      r.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // One quotient bit of the restoring division.
  function automatic dvs_t div_step(input dvs_t a);
    dvs_t r;
    logic [ROOT_W:0] t;
    logic [ROOT_W:0] d;
    r = a;
    t = {a.rem, 1'b0};
    d = t - {1'b0, a.seg_len};
    if (t >= {1'b0, a.seg_len}) begin
      r.rem = d[ROOT_W-1:0];
      r.q   = {a.q[SLOPE_W-2:0], 1'b1};
    end else begin
      r.rem = t[ROOT_W-1:0];
      r.q   = {a.q[SLOPE_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== src/lsfd_ram.sv =====
// Generic single-write, single-read RAM with registered, read-first output.
module lsfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/lidar_slope_feature_detector.sv =====
// LiDAR slope-difference feature detector top level.
//
// Grid points stream in row-major order and the block emits the points whose vertical slope
// differs from the slope one row above by more than the slope limit and whose range exceeds
// min_range. One point is taken every cycle unless the output stalls or the line buffers are
// being cleared; a point travels through 16 register stages (point capture with the
// line-buffer read, difference, squares, sums, six square-root stages, four division stages,
// slope-buffer compare, output register), and its feature is presented on m_tvalid from the
// output register. The whole pipeline holds only while the output register is full and not
// taken. After reset the line buffers are cleared one column per cycle, so no point is
// accepted until all 2048 columns are cleared; configuration writes are taken at any time.
module lidar_slope_feature_detector
  import lsfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // point_x, point_y, point_z, zero pad
  input  logic [0:0]  s_tuser,   // scan_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // feature_x, feature_y, feature_z, feature_label,
                                 // feature_row, feature_column, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  // Configuration registers.
  logic [SLOPE_W-1:0] slope_limit;
  logic [COORD_W-1:0] min_range;
  logic [LABEL_W-1:0] score_threshold;
  logic               map_empty;
  logic [CNT_W-1:0]   column_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slope_limit     <= SLOPE_W'(6554);
      min_range       <= COORD_W'(1000);
      score_threshold <= LABEL_W'(5);
      map_empty       <= 1'b1;
      column_count    <= MAX_COLS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SLOPE_LIMIT:     slope_limit     <= cfg_data[SLOPE_W-1:0];
        REG_MIN_RANGE:       min_range       <= cfg_data[COORD_W-1:0];
        REG_SCORE_THRESHOLD: score_threshold <= cfg_data[LABEL_W-1:0];
        REG_MAP_EMPTY:       map_empty       <= cfg_data[0];
        REG_COLUMN_COUNT:    column_count    <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Line-buffer clearing pass after reset.
  logic             clearing;
  logic [COL_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + COL_W'(1);
      if (&clr_addr) begin
        clearing <= 1'b0;
      end
    end
  end

  // The pipeline advances whenever the output register can take a new value.
  logic en;
  logic accept;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !clearing;
  assign accept   = s_tvalid && s_tready;

  // Grid position of the incoming point.
  logic [CNT_W-1:0] column_counter;
  logic [ROW_W-1:0] row_counter;
  logic [CNT_W-1:0] cols_eff;
  logic [CNT_W-1:0] col_base;
  logic [ROW_W-1:0] row_base;
  logic [CNT_W-1:0] acc_col;
  logic [ROW_W-1:0] acc_row;

  always_comb begin
    cols_eff = (column_count == '0 || column_count > MAX_COLS) ? MAX_COLS : column_count;
    col_base = s_tuser[0] ? '0 : column_counter;
    row_base = s_tuser[0] ? '0 : row_counter;
    acc_col  = col_base;
    acc_row  = row_base;
    if (col_base >= cols_eff) begin
      acc_col = '0;
      acc_row = (&row_base) ? row_base : row_base + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      row_counter    <= '0;
    end else if (accept) begin
      column_counter <= acc_col + CNT_W'(1);
      row_counter    <= acc_row;
    end
  end

  // Point line buffer: read the point above and write the new one in the same transfer.
  logic [3*COORD_W-1:0] xyz_rd;

  lsfd_ram #(.WIDTH(3*COORD_W), .DEPTH(MAX_COLUMNS)) u_xyz_ram (
    .clk   (clk),
    .we    (clearing || accept),
    .waddr (clearing ? clr_addr : acc_col[COL_W-1:0]),
    .wdata (clearing ? '0 : s_tdata[3*COORD_W-1:0]),
    .re    (en),
    .raddr (acc_col[COL_W-1:0]),
    .rdata (xyz_rd)
  );

  // Stage 1: point and position.
  ctx_t c1;
  always_ff @(posedge clk) begin
    if (rst) begin
      c1.vld <= 1'b0;
    end else if (en) begin
      c1.vld    <= accept;
      c1.x      <= s_tdata[COORD_W-1:0];
      c1.y      <= s_tdata[2*COORD_W-1:COORD_W];
      c1.z      <= s_tdata[3*COORD_W-1:2*COORD_W];
      c1.row    <= acc_row;
      c1.col    <= acc_col[COL_W-1:0];
      c1.row_ok <= acc_row != '0;
      c1.far    <= 1'b0;
      c1.adz    <= '0;
    end
  end

  // Stage 2: absolute coordinate differences and absolute coordinates.
  ctx_t               c2;
  ctx_t               c2_next;
  logic [COORD_W-1:0] adx2, ady2, ax2, ay2, az2;
  logic [COORD_W:0]   dx, dy, dz, adx_w, ady_w, adz_w;

  always_comb begin
    dx    = {c1.x[COORD_W-1], c1.x} - {xyz_rd[COORD_W-1], xyz_rd[COORD_W-1:0]};
    dy    = {c1.y[COORD_W-1], c1.y} -
            {xyz_rd[2*COORD_W-1], xyz_rd[2*COORD_W-1:COORD_W]};
    dz    = {c1.z[COORD_W-1], c1.z} -
            {xyz_rd[3*COORD_W-1], xyz_rd[3*COORD_W-1:2*COORD_W]};
    adx_w = abs_diff(dx);
    ady_w = abs_diff(dy);
    adz_w = abs_diff(dz);
    c2_next     = c1;
    c2_next.adz = adz_w[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c2.vld <= 1'b0;
    end else if (en) begin
      c2     <= c2_next;
      adx2   <= adx_w[COORD_W-1:0];
      ady2   <= ady_w[COORD_W-1:0];
      ax2    <= abs_coord(c1.x);
      ay2    <= abs_coord(c1.y);
      az2    <= abs_coord(c1.z);
    end
  end

  // Stage 3: squares.
  ctx_t                 c3;
  logic [2*COORD_W-1:0] dsx, dsy, dsz, psx, psy, psz, m2;

  always_ff @(posedge clk) begin
    if (rst) begin
      c3.vld <= 1'b0;
    end else if (en) begin
      c3  <= c2;
      dsx <= adx2 * adx2;
      dsy <= ady2 * ady2;
      dsz <= c2.adz * c2.adz;
      psx <= ax2 * ax2;
      psy <= ay2 * ay2;
      psz <= az2 * az2;
      m2  <= min_range * min_range;
    end
  end

  // Stage 4: squared length and the range test.
  ctx_t             c4;
  ctx_t             c4_next;
  logic [SUM_W-1:0] len_sq;
  logic [SUM_W-1:0] r2;

  always_comb begin
    r2          = SUM_W'(psx) + SUM_W'(psy) + SUM_W'(psz);
    c4_next     = c3;
    c4_next.far = r2 > SUM_W'(m2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c4.vld <= 1'b0;
    end else if (en) begin
      c4     <= c4_next;
      len_sq <= SUM_W'(dsx) + SUM_W'(dsy) + SUM_W'(dsz);
    end
  end

  // Square-root stages, four digits each but one in the last.
  ctx_t sq_ctx [SQ_STAGES+1];
  sqs_t sq_st  [SQ_STAGES+1];

  always_comb begin
    sq_ctx[0]      = c4;
    sq_st[0].n     = len_sq;
    sq_st[0].rem   = '0;
    sq_st[0].root  = '0;
  end

  for (genvar s = 1; s <= SQ_STAGES; s++) begin : g_sqrt
    sqs_t nxt;
    always_comb begin
      nxt = sq_st[s-1];
      for (int k = 0; k < SQ_PER; k++) begin
        if ((s-1)*SQ_PER + k < SQ_STEPS) begin
          nxt = sqrt_step(nxt);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_ctx[s].vld <= 1'b0;
      end else if (en) begin
        sq_ctx[s] <= sq_ctx[s-1];
        sq_st[s]  <= nxt;
      end
    end
  end

  // Division stages: |dz| * 2^16 / length, four quotient bits each.
  ctx_t dv_ctx [DV_STAGES+1];
  dvs_t dv_st  [DV_STAGES+1];

  always_comb begin
    dv_ctx[0]        = sq_ctx[SQ_STAGES];
    dv_st[0].seg_len = sq_st[SQ_STAGES].root;
    dv_st[0].rem     = ROOT_W'(sq_ctx[SQ_STAGES].adz);
    dv_st[0].q       = '0;
    dv_st[0].zero    = sq_st[SQ_STAGES].root == '0;
    dv_st[0].sat     = ROOT_W'(sq_ctx[SQ_STAGES].adz) == sq_st[SQ_STAGES].root;
  end

  for (genvar s = 1; s <= DV_STAGES; s++) begin : g_div
    dvs_t nxt;
    always_comb begin
      nxt = dv_st[s-1];
      for (int k = 0; k < DV_PER; k++) begin
        nxt = div_step(nxt);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_ctx[s].vld <= 1'b0;
      end else if (en) begin
        dv_ctx[s] <= dv_ctx[s-1];
        dv_st[s]  <= nxt;
      end
    end
  end

  // Final stage: slope of this segment; the slope above arrives from the slope buffer.
  ctx_t               fc;
  logic [SLOPE_W-1:0] fs;
  logic               fv;
  logic [SLOPE_W:0]   slope_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fc.vld <= 1'b0;
    end else if (en) begin
      fc <= dv_ctx[DV_STAGES];
      fv <= dv_ctx[DV_STAGES].row_ok && !dv_st[DV_STAGES].zero;
      if (dv_st[DV_STAGES].zero || !dv_ctx[DV_STAGES].row_ok) begin
        fs <= '0;
      end else if (dv_st[DV_STAGES].sat) begin
        fs <= '1;
      end else begin
        fs <= dv_st[DV_STAGES].q;
      end
    end
  end

  lsfd_ram #(.WIDTH(SLOPE_W+1), .DEPTH(MAX_COLUMNS)) u_slope_ram (
    .clk   (clk),
    .we    (clearing || (en && fc.vld)),
    .waddr (clearing ? clr_addr : fc.col),
    .wdata (clearing ? '0 : {fv, fs}),
    .re    (en),
    .raddr (dv_ctx[DV_STAGES].col),
    .rdata (slope_rd)
  );

  logic               feature;
  logic [SLOPE_W-1:0] diff;
  logic [LABEL_W-1:0] label;

  always_comb begin
    diff    = (fs > slope_rd[SLOPE_W-1:0]) ? fs - slope_rd[SLOPE_W-1:0]
                                           : slope_rd[SLOPE_W-1:0] - fs;
    feature = fc.vld && fv && slope_rd[SLOPE_W] && (diff > slope_limit) && fc.far;
    if (!map_empty) begin
      label = LABEL_W'(1);
    end else if (&score_threshold) begin
      label = score_threshold;
    end else begin
      label = score_threshold + LABEL_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= feature;
      m_tdata  <= {1'b0, fc.col, fc.row, label, fc.z, fc.y, fc.x};
    end
  end

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready) else $error("point accepted during line-buffer clear");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready) else $error("point accepted while output stalled");

  a_no_row0_feature: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[75:68] != '0) else $error("feature reported in row zero");

  a_counter_range: assert property (@(posedge clk) disable iff (rst)
    column_counter <= MAX_COLS) else $error("column counter beyond maximum");

endmodule

// ===== tb/sv/lidar_slope_feature_checker.sv =====
// Checker for the LiDAR slope feature detector: predicts features from accepted points.
module lidar_slope_feature_checker
  import lsfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [87:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  // Packed from the most significant field down, so x lands in the lowest bits.
  typedef struct packed {
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [LABEL_W-1:0] label;
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } feature_t;

  feature_t features_due[$];

  logic signed [COORD_W-1:0] above_x [MAX_COLUMNS];
  logic signed [COORD_W-1:0] above_y [MAX_COLUMNS];
  logic signed [COORD_W-1:0] above_z [MAX_COLUMNS];
  logic [SLOPE_W-1:0]        above_slope [MAX_COLUMNS];
  logic                      above_ok [MAX_COLUMNS];
  int unsigned col_pos, row_pos;
  logic [15:0] thr;
  logic [19:0] rmin;
  logic [7:0]  score;
  logic        empty_map;
  logic [11:0] ncols;

  assign pending = features_due.size();

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned square(longint d);
    if (d < 0) d = -d;
    return d * d;
  endfunction

  task automatic predict_point(logic [63:0] d, logic start);
    logic signed [COORD_W-1:0] px, py, pz;
    int unsigned lim, c;
    longint dx, dy, dz;
    longint unsigned seg_len, q, slope;
    logic ok;
    feature_t f;
    px = d[19:0];
    py = d[39:20];
    pz = d[59:40];
    lim = (ncols == 0 || ncols > MAX_COLUMNS) ? MAX_COLUMNS : ncols;
    if (start) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= lim) begin
      col_pos = 0;
      if (row_pos < 255) row_pos++;
    end
    c = col_pos;
    slope = 0;
    ok = 0;
    if (row_pos >= 1) begin
      dx = longint'(px) - longint'(above_x[c]);
      dy = longint'(py) - longint'(above_y[c]);
      dz = longint'(pz) - longint'(above_z[c]);
      seg_len = int_sqrt(square(dx) + square(dy) + square(dz));
      if (seg_len != 0) begin
        q = ((dz < 0 ? -dz : dz) << SLOPE_W) / seg_len;
        slope = (q > 65535) ? 65535 : q;
        ok = 1;
      end
    end
    if (ok && above_ok[c]) begin
      q = (slope > above_slope[c]) ? slope - above_slope[c] : above_slope[c] - slope;
      if (q > thr && square(px) + square(py) + square(pz) > longint'(rmin) * rmin) begin
        f.x = px;
        f.y = py;
        f.z = pz;
        f.label = empty_map ? ((score == 8'hff) ? 8'hff : score + 8'd1) : 8'd1;
        f.row = row_pos[7:0];
        f.col = c[COL_W-1:0];
        features_due = {features_due, f};
      end
    end
    above_x[c] = px;
    above_y[c] = py;
    above_z[c] = pz;
    above_slope[c] = slope[15:0];
    above_ok[c] = ok;
    col_pos = c + 1;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    feature_t want, got;
    if (rst) begin
      fail_count = 0;
      features_due.delete();
      for (int i = 0; i < MAX_COLUMNS; i++) begin
        above_x[i] = 0; above_y[i] = 0; above_z[i] = 0;
        above_slope[i] = 0; above_ok[i] = 0;
      end
      col_pos = 0; row_pos = 0;
      thr = 16'd6554; rmin = 20'd1000; score = 8'd5; empty_map = 1'b1; ncols = 12'd2048;
    end else begin
      // The output side is checked before the input transfer of the same edge is predicted,
      // since no feature can leave in the cycle its point is taken.
      if (m_tvalid && m_tready) begin
        got = m_tdata[86:0];
        if (features_due.size() == 0) begin
          report_mismatch("unexpected feature, column", got.col, -1);
        end else begin
          want = features_due.pop_front();
          if (got.x != want.x) report_mismatch("feature_x", got.x, want.x);
          if (got.y != want.y) report_mismatch("feature_y", got.y, want.y);
          if (got.z != want.z) report_mismatch("feature_z", got.z, want.z);
          if (got.label != want.label) report_mismatch("feature_label", got.label, want.label);
          if (got.row != want.row) report_mismatch("feature_row", got.row, want.row);
          if (got.col != want.col) report_mismatch("feature_column", got.col, want.col);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SLOPE_LIMIT:     thr = cfg_data[15:0];
          REG_MIN_RANGE:       rmin = cfg_data;
          REG_SCORE_THRESHOLD: score = cfg_data[7:0];
          REG_MAP_EMPTY:       empty_map = cfg_data[0];
          REG_COLUMN_COUNT:    ncols = cfg_data[11:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_point(s_tdata, s_tuser[0]);
    end
  end

endmodule

// ===== tb/sv/lidar_slope_feature_detector_test.sv =====
// Testbench top for the LiDAR slope feature detector: stimulus, idling phases and verdict.
module lidar_slope_feature_detector_test
  import lsfd_pkg::*;
();

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [63:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid, m_tready;
  logic [87:0] m_tdata;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [19:0] cfg_data;
  int          fail_count, pending;

  // Idle percentages of the sender and the receiver; changed between phases.
  int unsigned send_idle, recv_idle;
  // While set, the receiver refuses every transfer so the pipeline backs up.
  logic        hold_off;
  longint      cycles;

  // The pipeline is 16 stages deep; this much quiet time covers any point still in flight.
  localparam int DRAIN_CYCLES = 40;
  localparam longint CYCLE_LIMIT = 400000;

  lidar_slope_feature_detector u_top (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  lidar_slope_feature_checker u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random stalls at the falling edge, or a full hold-off when asked.
  always @(negedge clk) begin
    if (hold_off) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog: the slowest correct run is far below this count.
  always @(posedge clk) begin
    if (rst) begin
      cycles <= 0;
    end else begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Offers one point and waits for its transfer; idle cycles go in front at random.
  // The valid stays up on return, so the next point can follow without a gap.
  task automatic send_point(logic signed [19:0] x, logic signed [19:0] y,
                            logic signed [19:0] z, logic start);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, z, y, x};
    s_tuser  <= start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [19:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stops offering, waits until every predicted feature has been taken, then lets the
  // pipeline empty.
  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // A scan with a small row width: most points sit on a smooth surface with steps in z,
  // so slope changes appear often; some points are raw noise over the whole range.
  task automatic send_scan(int unsigned ncols, int unsigned nrows);
    logic signed [19:0] x, y, z;
    for (int r = 0; r < nrows; r++) begin
      for (int c = 0; c < ncols; c++) begin
        if ($urandom_range(9) == 0) begin
          x = 20'($urandom); y = 20'($urandom); z = 20'($urandom);
        end else begin
          x = 20'(2000 + 37 * c + $urandom_range(50));
          y = 20'(-3000 + 41 * r + $urandom_range(50));
          z = 20'($urandom_range(3) == 0 ? $urandom_range(4000) - 2000 : 25 * r);
        end
        send_point(x, y, z, (r == 0 && c == 0) ? 1'b1 : 1'b0);
      end
    end
  endtask

  initial begin
    logic signed [19:0] ext [4];
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
    cfg_valid = 1'b0; cfg_index = REG_SLOPE_LIMIT; cfg_data = '0;
    send_idle = 0; recv_idle = 0; hold_off = 1'b0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: 16 columns, extreme coordinates stacked over four rows, a repeated
    // point for a zero-length segment, and the saturating label.
    write_reg(REG_COLUMN_COUNT, 20'd16);
    write_reg(REG_SLOPE_LIMIT, 20'd0);
    write_reg(REG_MIN_RANGE, 20'd0);
    write_reg(REG_SCORE_THRESHOLD, 20'd255);
    ext[0] = 20'sh80000; ext[1] = 20'sh7ffff; ext[2] = 20'sd0; ext[3] = -20'sd1;
    for (int r = 0; r < 4; r++) begin
      send_point(ext[r], ext[3 - r], ext[(r + 1) % 4], r == 0);
      // Column 1 repeats its point in rows 1 and 2, a zero-length segment.
      send_point(20'sd5, 20'sd5, 20'(((r == 2) ? 1 : r) * 100), 1'b0);
      // The rest of the row, so the next row starts at column 0 again.
      for (int c = 2; c < 16; c++) begin
        send_point(20'(3000 + 10 * c), 20'sd2500, 20'(r * 40), 1'b0);
      end
    end
    drain();

    // Random phases, each with its own idling and its own register setting.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 67; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 67; end
        default: begin send_idle = 35; recv_idle = 35; end
      endcase
      write_reg(REG_SLOPE_LIMIT, (ph == 7) ? 20'hffff : 20'($urandom_range(8000)));
      write_reg(REG_MIN_RANGE, (ph == 6) ? 20'hfffff : 20'($urandom_range(3000)));
      write_reg(REG_SCORE_THRESHOLD, 20'($urandom_range(255)));
      write_reg(REG_MAP_EMPTY, 20'(ph % 2));
      write_reg(REG_COLUMN_COUNT, (ph == 5) ? 20'd0 : 20'(16 + $urandom_range(4)));
      if (ph == 3) begin
        // Long receiver hold-off while points keep coming, so the block stalls its input.
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(negedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      if (ph == 5) send_scan(20, 4);
      else send_scan(16, 5);
      // Sender pauses until every expected feature has arrived.
      drain();
    end

    drain();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lsfd_pkg.sv
src/lsfd_ram.sv
src/lidar_slope_feature_detector.sv
tb/sv/lidar_slope_feature_checker.sv
tb/sv/lidar_slope_feature_detector_test.sv
